/* rtl/core/pct_pkg.sv */
// ----------------------------------------------------------------------------
// pct_pkg: shared types and helpers for the permutation cycle-type filter
// Packed permutation type, code widths, register indexes and the image
// lookup and composition functions used by the datapath modules.
// ----------------------------------------------------------------------------
package pct_pkg;

	// Number of points moved by a permutation, and palette depth.
	localparam int POINTS        = 10;
	localparam int PALETTE_SLOTS = 6;

	// Field widths.
	localparam int NIB_W     = 4;
	localparam int IDX_W     = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int LEN_W     = $clog2(POINTS + 1);
	localparam int PERM_W    = POINTS * NIB_W;
	localparam int CODE_W    = (POINTS + 1) * NIB_W;
	localparam int CNT_W     = 3;
	localparam int CFG_W     = CODE_W;
	localparam int CFG_IDX_W = $clog2(2 + PALETTE_SLOTS);

	// Configuration register indexes; palette entry k sits at REG_PAL_BASE + k.
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROOT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PAL_COUNT = CFG_IDX_W'(1);
	localparam int                   REG_PAL_BASE  = 2;

	// One image and one whole permutation; element i is the image of point i.
	typedef logic [NIB_W-1:0] img_t;
	typedef img_t [POINTS-1:0] perm_t;

	// Image of point i under a, or zero when i is not a point.
	function automatic img_t perm_at(perm_t a, img_t i);
		img_t r;
		r = '0;
		if (i < NIB_W'(POINTS)) begin
			r = a[i[IDX_W-1:0]];
		end
		return r;
	endfunction

	// Composition: result maps p to a(b(p)).
	function automatic perm_t perm_compose(perm_t a, perm_t b);
		perm_t r;
		for (int p = 0; p < POINTS; p++) begin
			r[p] = perm_at(a, b[p]);
		end
		return r;
	endfunction

	// True when every image is a point and no two images are equal.
	function automatic logic perm_valid(perm_t a);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < POINTS; i++) begin
			if (a[i] >= NIB_W'(POINTS)) begin
				ok = 1'b0;
			end
			for (int j = i + 1; j < POINTS; j++) begin
				if (a[i] == a[j]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	// Identity permutation.
	function automatic perm_t perm_identity();
		perm_t r;
		for (int p = 0; p < POINTS; p++) begin
			r[p] = NIB_W'(p);
		end
		return r;
	endfunction

endpackage

/* rtl/core/permutation_cycle_type_filter_top.sv */
// ----------------------------------------------------------------------------
// permutation_cycle_type_filter_top: cycle-type palette filter
// Computes the cycle-type codes of a candidate permutation and of the
// candidate composed with a configured inverse root, and checks both codes
// against a palette of allowed codes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, candidate_perm) takes one candidate
// permutation per item. The output channel (out_valid, out_ready) returns one
// result item per input item, in order: both codes, both palette hits, the
// accept flag and the bad-permutation flag.
// An accepted item is captured in the input register, and its result is then
// loaded into the output register as soon as that register is empty or drained,
// which raises out_valid. Throughput is one item per cycle while the receiver
// does not stall. The power table, cycle-length search and both sets of six
// palette compares sit between the input and output registers.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more; in_ready falls only when both are full.
// Reset clears both valid flags, sets the inverse root to the identity and
// clears the palette count and codes. The configuration port writes one
// register per cycle with cfg_we and should be used while the block is idle.
// ----------------------------------------------------------------------------
module permutation_cycle_type_filter_top
	import pct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PERM_W-1:0]    candidate_perm,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CODE_W-1:0]    candidate_code,
	output logic [CODE_W-1:0]    relative_code,
	output logic                 candidate_allowed,
	output logic                 relative_allowed,
	output logic                 accept,
	output logic                 bad_perm
);

	// Configuration registers.
	perm_t             inv_root_q;
	logic [CNT_W-1:0]  pal_count_q;
	logic [CODE_W-1:0] pal_code_q [PALETTE_SLOTS];

	// Input register.
	logic              valid_s1;
	perm_t             cand_s1;

	// Output register.
	logic              out_valid_q;
	logic [CODE_W-1:0] cand_code_q;
	logic [CODE_W-1:0] rel_code_q;
	logic              cand_allow_q;
	logic              rel_allow_q;
	logic              accept_q;
	logic              bad_q;

	// Datapath between the two registers.
	perm_t             rel_perm;
	logic [CODE_W-1:0] cand_code_raw;
	logic [CODE_W-1:0] rel_code_raw;
	logic              cand_ok;
	logic              inv_ok;
	logic              cand_hit;
	logic              rel_hit;
	logic              advance;

	// Match a code against the active palette entries; a count above the
	// number of slots simply enables all of them.
	function automatic logic in_palette(logic [CODE_W-1:0] c, logic [CNT_W-1:0] n,
			logic [CODE_W-1:0] pal [PALETTE_SLOTS]);
		logic hit_any;
		hit_any = 1'b0;
		for (int k = 0; k < PALETTE_SLOTS; k++) begin
			if ((CNT_W'(k) < n) && (pal[k] == c)) begin
				hit_any = 1'b1;
			end
		end
		return hit_any;
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_root_q  <= perm_identity();
			pal_count_q <= '0;
			for (int k = 0; k < PALETTE_SLOTS; k++) begin
				pal_code_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_ROOT: begin
					inv_root_q <= cfg_data[PERM_W-1:0];
				end
				REG_PAL_COUNT: begin
					pal_count_q <= cfg_data[CNT_W-1:0];
				end
				default: begin
					for (int k = 0; k < PALETTE_SLOTS; k++) begin
						if (cfg_index == CFG_IDX_W'(REG_PAL_BASE + k)) begin
							pal_code_q[k] <= cfg_data[CODE_W-1:0];
						end
					end
				end
			endcase
		end
	end

	// Pipeline flow: the output register loads whenever it is empty or drained.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cand_s1 <= candidate_perm;
		end
	end

	// Relative permutation and validity checks.
	assign rel_perm = perm_compose(cand_s1, inv_root_q);
	assign cand_ok  = perm_valid(cand_s1);
	assign inv_ok   = perm_valid(inv_root_q);

	pct_cycle_type u_cand_type (
		.perm (cand_s1),
		.code (cand_code_raw)
	);

	pct_cycle_type u_rel_type (
		.perm (rel_perm),
		.code (rel_code_raw)
	);

	// Palette lookups.
	assign cand_hit = in_palette(cand_code_raw, pal_count_q, pal_code_q);
	assign rel_hit  = in_palette(rel_code_raw, pal_count_q, pal_code_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			cand_code_q  <= cand_ok ? cand_code_raw : '0;
			rel_code_q   <= (cand_ok && inv_ok) ? rel_code_raw : '0;
			cand_allow_q <= cand_ok && cand_hit;
			rel_allow_q  <= cand_ok && inv_ok && rel_hit;
			accept_q     <= cand_ok && inv_ok && cand_hit && rel_hit;
			bad_q        <= !cand_ok;
		end
	end

	assign out_valid         = out_valid_q;
	assign candidate_code    = cand_code_q;
	assign relative_code     = rel_code_q;
	assign candidate_allowed = cand_allow_q;
	assign relative_allowed  = rel_allow_q;
	assign accept            = accept_q;
	assign bad_perm          = bad_q;

	// Accept only with both palette hits on a good candidate.
	a_accept_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && accept_q |-> cand_allow_q && rel_allow_q && !bad_q)
		else $error("accept set without both palette hits on a good candidate");

	// A bad candidate yields cleared codes and no palette hits.
	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> (cand_code_q == '0) && (rel_code_q == '0)
			&& !cand_allow_q && !rel_allow_q)
		else $error("bad candidate produced a nonzero result");

	// An item held in the input register during a stall is not lost.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cand_s1))
		else $error("input register item changed during a stall");

	// No cycle has length zero.
	a_nibble_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cand_code_q[NIB_W-1:0] == '0) && (rel_code_q[NIB_W-1:0] == '0))
		else $error("cycle-type code has a count in the length-zero nibble");

endmodule

/* rtl/core/pct_cycle_type.sv */
// ----------------------------------------------------------------------------
// pct_cycle_type: cycle-type code of one permutation
// Builds the powers of the permutation by squaring, finds each point's cycle
// length and whether it is the smallest point of its cycle, and counts the
// cycles of each length into one nibble of the code.
// ----------------------------------------------------------------------------
module pct_cycle_type
	import pct_pkg::*;
(
	input  perm_t               perm,
	output logic [CODE_W-1:0]   code
);

	perm_t             pw     [1:POINTS];
	logic [LEN_W-1:0]  len    [POINTS];
	logic [POINTS-1:0] leader;
	logic [POINTS-1:0] hit    [1:POINTS];

	// Powers of the permutation; each is a product of two lower powers, so
	// the lookup depth grows with the log of the exponent.
	assign pw[1] = perm;
	for (genvar k = 2; k <= POINTS; k++) begin : g_pow
		assign pw[k] = perm_compose(pw[k >> 1], pw[k - (k >> 1)]);
	end

	// Cycle length of each point, and whether it leads its cycle.
	always_comb begin
		for (int p = 0; p < POINTS; p++) begin
			len[p] = '0;
			for (int k = POINTS; k >= 1; k--) begin
				if (pw[k][p] == NIB_W'(p)) begin
					len[p] = LEN_W'(k);
				end
			end
			leader[p] = 1'b1;
			for (int k = 1; k < POINTS; k++) begin
				if (pw[k][p] < NIB_W'(p)) begin
					leader[p] = 1'b0;
				end
			end
		end
	end

	// One hit per cycle, sorted by cycle length.
	always_comb begin
		for (int l = 1; l <= POINTS; l++) begin
			for (int p = 0; p < POINTS; p++) begin
				hit[l][p] = leader[p] && (len[p] == LEN_W'(l));
			end
		end
	end

	// Nibble l counts the cycles of length l; nibble zero stays clear.
	always_comb begin
		code = '0;
		for (int l = 1; l <= POINTS; l++) begin
			code[l*NIB_W +: NIB_W] = NIB_W'($countones(hit[l]));
		end
	end

endmodule

/* tb/permutation_cycle_type_filter_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// permutation_cycle_type_filter_top_tb: self-checking bench for the filter
// Drives candidate permutations through the valid/ready input channel and
// compares every result item with a table value or a local predictor that
// rebuilds both cycle-type codes and the palette hits from register shadows.
// A short directed table comes first. Random phases follow, each with its own
// register setting, under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module permutation_cycle_type_filter_top_tb;
	import pct_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int REPORT_MAX      = 10;

	// Well-known permutations and their cycle-type codes.
	localparam logic [PERM_W-1:0] PERM_ID       = 40'h9876543210;
	localparam logic [PERM_W-1:0] PERM_ROT      = 40'h0987654321;
	localparam logic [PERM_W-1:0] PERM_ROT_INV  = 40'h8765432109;
	localparam logic [PERM_W-1:0] PERM_SWAP     = 40'h9876543201;
	localparam logic [PERM_W-1:0] PERM_FIVES    = 40'h1098765432;
	localparam logic [CODE_W-1:0] CODE_ID       = 44'h000_0000_00A0;
	localparam logic [CODE_W-1:0] CODE_ROT      = 44'h100_0000_0000;
	localparam logic [CODE_W-1:0] CODE_SWAP     = 44'h000_0000_0180;
	localparam logic [CODE_W-1:0] CODE_FIVES    = 44'h000_0020_0000;
	localparam logic [CFG_W-1:0]  CFG_ALL_ONES  = {CFG_W{1'b1}};

	typedef struct packed {
		logic [CODE_W-1:0] cand_code;
		logic [CODE_W-1:0] rel_code;
		logic              cand_hit;
		logic              rel_hit;
		logic              accepted;
		logic              bad;
	} filter_result_t;

	// One row of the directed table: a register write or a candidate item.
	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CFG_W-1:0]     value;
		bit                   typed;
		filter_result_t       want;
	} directed_row_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [PERM_W-1:0]    candidate_perm = '0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [CODE_W-1:0]    candidate_code;
	logic [CODE_W-1:0]    relative_code;
	logic                 candidate_allowed;
	logic                 relative_allowed;
	logic                 accept;
	logic                 bad_perm;

	// Shadow of the configuration registers.
	perm_t             root_shadow;
	logic [CNT_W-1:0]  count_shadow;
	logic [CODE_W-1:0] palette_shadow [PALETTE_SLOTS];

	filter_result_t pending_results [$];
	directed_row_t  directed_rows [$];

	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int accepts_seen  = 0;
	int bad_seen      = 0;
	int settings_used = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	permutation_cycle_type_filter_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.candidate_perm    (candidate_perm),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.candidate_code    (candidate_code),
		.relative_code     (relative_code),
		.candidate_allowed (candidate_allowed),
		.relative_allowed  (relative_allowed),
		.accept            (accept),
		.bad_perm          (bad_perm)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// True when every image is a point and no image repeats.
	function automatic bit is_permutation(perm_t a);
		bit [15:0] seen;
		seen = '0;
		for (int i = 0; i < POINTS; i++) begin
			if (a[i] >= POINTS || seen[a[i]]) begin
				return 1'b0;
			end
			seen[a[i]] = 1'b1;
		end
		return 1'b1;
	endfunction

	// Nibble L of the code counts the cycles of length L; a must be valid.
	function automatic logic [CODE_W-1:0] cycle_type_code(perm_t a);
		bit [POINTS-1:0]   visited;
		logic [CODE_W-1:0] code;
		int                len;
		int                cur;
		visited = '0;
		code = '0;
		for (int p = 0; p < POINTS; p++) begin
			if (!visited[p]) begin
				len = 0;
				cur = p;
				do begin
					visited[cur] = 1'b1;
					cur = a[cur];
					len++;
				end while (cur != p);
				code = code + (CODE_W'(1) << (NIB_W * len));
			end
		end
		return code;
	endfunction

	// A count above the number of slots acts as the number of slots.
	function automatic bit palette_hit(logic [CODE_W-1:0] code);
		int n;
		n = (count_shadow > PALETTE_SLOTS) ? PALETTE_SLOTS : int'(count_shadow);
		for (int k = 0; k < n; k++) begin
			if (palette_shadow[k] == code) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Expected result of one candidate under the current register shadow.
	function automatic filter_result_t predict_filter(perm_t cand);
		filter_result_t r;
		perm_t          rel;
		bit             cand_ok;
		bit             root_ok;
		r = '0;
		cand_ok = is_permutation(cand);
		root_ok = is_permutation(root_shadow);
		r.bad = !cand_ok;
		if (cand_ok) begin
			r.cand_code = cycle_type_code(cand);
			r.cand_hit = palette_hit(r.cand_code);
			if (root_ok) begin
				for (int p = 0; p < POINTS; p++) begin
					rel[p] = cand[root_shadow[p]];
				end
				r.rel_code = cycle_type_code(rel);
				r.rel_hit = palette_hit(r.rel_code);
			end
		end
		r.accepted = cand_ok && root_ok && r.cand_hit && r.rel_hit;
		return r;
	endfunction

	function automatic filter_result_t outcome(logic [CODE_W-1:0] cc, logic [CODE_W-1:0] rc,
			logic ch, logic rh, logic acc, logic bad);
		filter_result_t r;
		r.cand_code = cc;
		r.rel_code = rc;
		r.cand_hit = ch;
		r.rel_hit = rh;
		r.accepted = acc;
		r.bad = bad;
		return r;
	endfunction

	function automatic perm_t shuffled_perm();
		perm_t r;
		img_t  t;
		int    j;
		for (int p = 0; p < POINTS; p++) begin
			r[p] = img_t'(p);
		end
		for (int i = POINTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = r[i];
			r[i] = r[j];
			r[j] = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] random_wide();
		return {$urandom, $urandom};
	endfunction

	// Mostly valid permutations, some with one image spoiled, some raw noise.
	function automatic perm_t random_candidate();
		perm_t       r;
		logic [63:0] wide;
		int          pick;
		pick = $urandom_range(0, 99);
		r = shuffled_perm();
		if (pick >= 85) begin
			wide = random_wide();
			r = wide[PERM_W-1:0];
		end else if (pick >= 70) begin
			r[$urandom_range(0, POINTS - 1)] = img_t'($urandom_range(0, 15));
		end
		return r;
	endfunction

	function automatic void add_row(bit is_write, logic [CFG_IDX_W-1:0] idx,
			logic [CFG_W-1:0] value, bit typed, filter_result_t want);
		directed_row_t row;
		row.is_write = is_write;
		row.reg_index = idx;
		row.value = value;
		row.typed = typed;
		row.want = want;
		directed_rows = {directed_rows, row};
	endfunction

	// Write one register; cfg_we stays high until the writes are closed.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_INV_ROOT) begin
			root_shadow = value[PERM_W-1:0];
		end else if (idx == REG_PAL_COUNT) begin
			count_shadow = value[CNT_W-1:0];
		end else begin
			palette_shadow[int'(idx) - REG_PAL_BASE] = value[CODE_W-1:0];
		end
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Stop sending and wait until every expected item has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Offer one candidate, with a random gap first, and record its result.
	task automatic send_candidate(input perm_t perm, input bit typed,
			input filter_result_t want);
		filter_result_t want_r;
		want_r = typed ? want : predict_filter(perm);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		candidate_perm <= perm;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_results = {pending_results, want_r};
		items_sent++;
	endtask

	// Receiver: random stalls and the check of every accepted result item.
	always @(posedge clk) begin
		filter_result_t got;
		filter_result_t want;
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (out_valid && out_ready) begin
			got = outcome(candidate_code, relative_code, candidate_allowed, relative_allowed,
				accept, bad_perm);
			results_seen++;
			if (accept === 1'b1) begin
				accepts_seen++;
			end
			if (bad_perm === 1'b1) begin
				bad_seen++;
			end
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("Cycle %0d: result item with no expectation waiting", cycles);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("Cycle %0d mismatch (expected/actual): candidate_code %h/%h",
							cycles, want.cand_code, got.cand_code);
						$display("  relative_code %h/%h allowed %b%b/%b%b accept %b/%b bad %b/%b",
							want.rel_code, got.rel_code, want.cand_hit, want.rel_hit,
							got.cand_hit, got.rel_hit, want.accepted, got.accepted,
							want.bad, got.bad);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycles,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus: directed table, then random phases.
	initial begin
		bit               writing;
		logic [CFG_W-1:0] root_value;
		logic [CFG_W-1:0] code_value;
		logic [63:0]      wide;
		int               count;

		for (int p = 0; p < POINTS; p++) begin
			root_shadow[p] = img_t'(p);
		end
		count_shadow = '0;
		for (int k = 0; k < PALETTE_SLOTS; k++) begin
			palette_shadow[k] = '0;
		end

		// After reset: empty palette, identity root.
		add_row(1'b0, '0, PERM_ID, 1'b1,
			outcome(CODE_ID, CODE_ID, 1'b0, 1'b0, 1'b0, 1'b0));
		add_row(1'b0, '0, {PERM_W{1'b1}}, 1'b1,
			outcome('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
		add_row(1'b0, '0, '0, 1'b1, outcome('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
		add_row(1'b0, '0, 40'h987654321A, 1'b1,
			outcome('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
		add_row(1'b0, '0, PERM_ROT, 1'b1,
			outcome(CODE_ROT, CODE_ROT, 1'b0, 1'b0, 1'b0, 1'b0));
		add_row(1'b0, '0, PERM_SWAP, 1'b0, '0);
		// Oversized count, full palette with both code extremes.
		add_row(1'b1, REG_PAL_COUNT, CFG_W'(7), 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 0), CODE_ID, 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 1), CODE_ROT, 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 2), CFG_ALL_ONES, 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 3), CODE_SWAP, 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 4), '0, 1'b0, '0);
		add_row(1'b1, CFG_IDX_W'(REG_PAL_BASE + 5), CODE_FIVES, 1'b0, '0);
		add_row(1'b0, '0, PERM_ID, 1'b1,
			outcome(CODE_ID, CODE_ID, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(1'b0, '0, PERM_ROT, 1'b1,
			outcome(CODE_ROT, CODE_ROT, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(1'b0, '0, PERM_SWAP, 1'b0, '0);
		add_row(1'b0, '0, PERM_FIVES, 1'b0, '0);
		// A bad candidate gets no hit even though code zero is in the palette.
		add_row(1'b0, '0, {PERM_W{1'b1}}, 1'b1,
			outcome('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
		// Rotated root.
		add_row(1'b1, REG_INV_ROOT, PERM_ROT, 1'b0, '0);
		add_row(1'b0, '0, PERM_ID, 1'b0, '0);
		add_row(1'b0, '0, PERM_ROT_INV, 1'b0, '0);
		// Roots that are not permutations kill the relative side only.
		add_row(1'b1, REG_INV_ROOT, CFG_ALL_ONES, 1'b0, '0);
		add_row(1'b0, '0, PERM_ID, 1'b1,
			outcome(CODE_ID, '0, 1'b1, 1'b0, 1'b0, 1'b0));
		add_row(1'b1, REG_INV_ROOT, '0, 1'b0, '0);
		add_row(1'b0, '0, PERM_SWAP, 1'b0, '0);
		// Single palette entry.
		add_row(1'b1, REG_INV_ROOT, PERM_ID, 1'b0, '0);
		add_row(1'b1, REG_PAL_COUNT, CFG_W'(1), 1'b0, '0);
		add_row(1'b0, '0, PERM_ID, 1'b1,
			outcome(CODE_ID, CODE_ID, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(1'b0, '0, PERM_ROT, 1'b1,
			outcome(CODE_ROT, CODE_ROT, 1'b0, 1'b0, 1'b0, 1'b0));

		send_idle_pct = 6;
		recv_idle_pct = 46;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		writing = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				if (!writing) begin
					drain();
					writing = 1'b1;
				end
				write_reg(directed_rows[i].reg_index, directed_rows[i].value);
			end else begin
				if (writing) begin
					close_writes();
					writing = 1'b0;
				end
				send_candidate(directed_rows[i].value[PERM_W-1:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random phases, each with a fresh register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 46 : 0;
			recv_idle_pct = (ph < 3) ? 46 : (ph < 6) ? 6 : 0;
			drain();

			case ($urandom_range(0, 9))
				0: begin
					wide = random_wide();
					root_value = wide[CFG_W-1:0];
				end
				1: root_value = CFG_W'(PERM_ID);
				default: root_value = CFG_W'(shuffled_perm());
			endcase
			if (ph == 0) begin
				root_value = CFG_W'(PERM_ID);
			end else if (ph == 4) begin
				root_value = CFG_ALL_ONES;
			end
			write_reg(REG_INV_ROOT, root_value);

			count = (ph == 0) ? 0 : (ph == 1) ? 7 : (ph == 2) ? PALETTE_SLOTS :
				$urandom_range(1, 7);
			write_reg(REG_PAL_COUNT, CFG_W'(count));

			for (int k = 0; k < PALETTE_SLOTS; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					wide = random_wide();
					code_value = wide[CFG_W-1:0];
				end else begin
					code_value = CFG_W'(cycle_type_code(shuffled_perm()));
				end
				write_reg(CFG_IDX_W'(REG_PAL_BASE + k), code_value);
			end
			close_writes();

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_candidate(random_candidate(), 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Summary: %0d candidates sent under %0d register settings, %0d results checked.",
			items_sent, settings_used, results_seen);
		$display("Summary: %0d accepted, %0d flagged as bad permutations, %0d mismatches.",
			accepts_seen, bad_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
